### rtl/ftfm_pkg.sv
package ftfm_pkg;

    // largest size code taken from an ID field
    localparam int MAX_SIZE_CODE = 7;

    localparam int BYTE_W = 8;
    localparam int FIELD_W = 3;
    localparam int SIZE_W = 3;
    localparam int COUNT_W = 15;
    localparam int CRC_W = 16;

    typedef logic [BYTE_W-1:0]  byte_t;
    typedef logic [FIELD_W-1:0] field_t;
    typedef logic [SIZE_W-1:0]  size_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [CRC_W-1:0]   crc_t;

    // field codes
    localparam field_t FIELD_GAP     = 3'd0;
    localparam field_t FIELD_ID      = 3'd1;
    localparam field_t FIELD_DATA    = 3'd2;
    localparam field_t FIELD_DELETED = 3'd3;
    localparam field_t FIELD_CRC     = 3'd4;

    // special track bytes
    localparam byte_t BYTE_F5       = 8'hF5;
    localparam byte_t BYTE_A1       = 8'hA1;
    localparam byte_t BYTE_F6       = 8'hF6;
    localparam byte_t BYTE_C2       = 8'hC2;
    localparam byte_t BYTE_CRC_MARK = 8'hF7;
    localparam byte_t MARK_ID       = 8'hFE;
    localparam byte_t MARK_DATA     = 8'hFB;
    localparam byte_t MARK_DELETED  = 8'hF8;

    localparam crc_t   CRC_PRESET  = 16'hCDB4;
    localparam crc_t   CRC_POLY    = 16'h1021;
    localparam count_t ID_LEN      = 15'd4;
    localparam count_t CRC_LEN     = 15'd2;
    localparam count_t SECTOR_BASE = 15'd128;
    localparam size_t  SIZE_RESET  = 3'd1;
    localparam size_t  SIZE_MAX    = size_t'(MAX_SIZE_CODE);

    // one byte into the crc-16, msb first
    function automatic crc_t crc_fold(input crc_t crc_in, input byte_t data);
        crc_t c;
        c = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[CRC_W-1])
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[CRC_W-2:0], 1'b0};
        end
        return c;
    endfunction

endpackage

### rtl/ftfm_track_if.sv
interface ftfm_track_if;
    import ftfm_pkg::*;

    logic  valid;
    logic  ready;
    byte_t track_byte;
    logic  start_of_track;

    modport source (output valid, output track_byte, output start_of_track, input ready);
    modport sink (input valid, input track_byte, input start_of_track, output ready);
endinterface

### rtl/ftfm_field_if.sv
interface ftfm_field_if;
    import ftfm_pkg::*;

    logic   valid;
    logic   ready;
    byte_t  out_byte;
    field_t field_code;

    modport source (output valid, output out_byte, output field_code, input ready);
    modport sink (input valid, input out_byte, input field_code, output ready);
endinterface

### rtl/floppy_track_field_marker.sv
// channel       | dir | payload                          | handshake
// --------------+-----+----------------------------------+-------------
// track         | in  | track_byte, start_of_track       | valid/ready
// marked        | out | out_byte, field_code             | valid/ready
// cfg           | in  | cfg_wdata (crc fix enable)       | cfg_we
//
// one byte per cycle sustained while the result side takes bytes: a byte is
// registered at the input, then the field parse, substitution and one
// byte-wide crc-16 update run combinationally into the result register.
// reset clears the parse state and sets crc fixing on.
// a stall on the result side holds both stages; the input stage still takes
// a transfer whenever it is free or moves on in the same cycle.
module floppy_track_field_marker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_wdata,
    ftfm_track_if.sink           track,
    ftfm_field_if.source         marked
);
    import ftfm_pkg::*;

    logic   crc_fix_reg;
    logic   s1_valid_reg;
    byte_t  s1_byte_reg;
    logic   s1_start_reg;
    logic   out_valid_reg;
    byte_t  out_byte_reg;
    field_t out_field_reg;

    field_t field_reg, field_next;
    count_t left_reg, left_next;
    size_t  size_reg, size_next;
    crc_t   crc_reg, crc_next;
    logic   low_pend_reg, low_pend_next;
    byte_t  low_byte_reg, low_byte_next;

    logic   advance;
    logic   take;
    field_t fld;
    count_t left;
    size_t  size;
    crc_t   crc;
    logic   low_pend;
    byte_t  low_byte;
    byte_t  b;
    logic   opened;

    assign advance = s1_valid_reg && (!out_valid_reg || marked.ready);
    assign track.ready = !s1_valid_reg || advance;
    assign take = track.valid && track.ready;

    assign marked.valid      = out_valid_reg;
    assign marked.out_byte   = out_byte_reg;
    assign marked.field_code = out_field_reg;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            crc_fix_reg <= 1'b1;
        else if (cfg_we)
            crc_fix_reg <= cfg_wdata;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (track.ready)
            s1_valid_reg <= track.valid;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_byte_reg  <= track.track_byte;
            s1_start_reg <= track.start_of_track;
        end
    end

    // parse, substitution and crc for the registered byte
    always_comb
    begin
        fld      = s1_start_reg ? FIELD_GAP : field_reg;
        left     = s1_start_reg ? '0 : left_reg;
        size     = s1_start_reg ? SIZE_RESET : size_reg;
        crc      = s1_start_reg ? CRC_PRESET : crc_reg;
        low_pend = s1_start_reg ? 1'b0 : low_pend_reg;
        low_byte = s1_start_reg ? '0 : low_byte_reg;

        b             = low_pend ? low_byte : s1_byte_reg;
        low_pend_next = 1'b0;
        low_byte_next = low_byte;
        field_next    = fld;
        left_next     = left;
        size_next     = size;
        opened        = 1'b0;

        // mark substitution and crc insertion
        if (crc_fix_reg)
        begin
            if (fld == FIELD_GAP)
            begin
                if (b == BYTE_F5)
                    b = BYTE_A1;
                else if (b == BYTE_F6)
                    b = BYTE_C2;
            end
            else if (fld == FIELD_CRC && !low_pend && b == BYTE_CRC_MARK)
            begin
                b             = crc[CRC_W-1:BYTE_W];
                low_byte_next = crc[BYTE_W-1:0];
                low_pend_next = 1'b1;
            end
        end

        // field counter
        if (left != '0)
        begin
            if (fld == FIELD_ID && left == count_t'(1))
                size_next = (b > byte_t'(SIZE_MAX)) ? SIZE_MAX : b[SIZE_W-1:0];
            left_next = left - count_t'(1);
            if (left == count_t'(1))
            begin
                if (fld != FIELD_CRC)
                begin
                    field_next = FIELD_CRC;
                    left_next  = CRC_LEN;
                end
                else
                    field_next = FIELD_GAP;
            end
        end
        else
        begin
            opened = 1'b1;
            if (b == MARK_ID)
            begin
                field_next = FIELD_ID;
                left_next  = ID_LEN;
            end
            else if (b == MARK_DATA)
            begin
                field_next = FIELD_DATA;
                left_next  = SECTOR_BASE << size;
            end
            else if (b == MARK_DELETED)
            begin
                field_next = FIELD_DELETED;
                left_next  = SECTOR_BASE << size;
            end
            else
            begin
                field_next = FIELD_GAP;
                opened     = 1'b0;
            end
        end

        crc_next = crc_fold(opened ? CRC_PRESET : crc, b);
    end

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_reg    <= FIELD_GAP;
            left_reg     <= '0;
            size_reg     <= SIZE_RESET;
            crc_reg      <= CRC_PRESET;
            low_pend_reg <= 1'b0;
            low_byte_reg <= '0;
        end
        else if (advance)
        begin
            field_reg    <= field_next;
            left_reg     <= left_next;
            size_reg     <= size_next;
            crc_reg      <= crc_next;
            low_pend_reg <= low_pend_next;
            low_byte_reg <= low_byte_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (marked.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg  <= b;
            out_field_reg <= fld;
        end
    end

    // checks
    a_left_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (left_reg == '0) |-> (field_reg == FIELD_GAP))
        else $error("empty byte count outside the gap");

    a_crc_len: assert property (@(posedge clk) disable iff (!rst_n)
        (field_reg == FIELD_CRC) |-> (left_reg == count_t'(1) || left_reg == CRC_LEN))
        else $error("crc field length out of range");

    a_low_used: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && low_pend_reg) |=> !low_pend_reg)
        else $error("pending crc low byte inserted twice");

    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed byte produced no result");

endmodule

### bench/ftfm_field_check.sv
`timescale 1ns / 1ps
module ftfm_field_check (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  cfg_we,
    input  logic  cfg_wdata,
    ftfm_track_if track,
    ftfm_field_if marked,
    output int    fail_count,
    output int    outstanding
);
    import ftfm_pkg::*;

    typedef struct packed {
        byte_t  out_byte;
        field_t field_code;
    } marked_byte_t;

    // results still owed by the block, oldest first
    marked_byte_t expected_marks[$];
    int errors = 0;

    // shadow of the crc fix register and the parse state
    logic   fix_enable = 1'b1;
    field_t cur_field = FIELD_GAP;
    count_t bytes_left = '0;
    size_t  size_code = SIZE_RESET;
    crc_t   running_crc = CRC_PRESET;
    logic   low_pending = 1'b0;
    byte_t  low_byte = '0;

    assign fail_count = errors;

    task automatic report_mismatch(input string what);
        errors++;
        $display("%0t ns  mismatch: %s", $time, what);
    endtask

    // bit-serial crc-16 ccitt, msb first
    function automatic crc_t crc_shift(input crc_t crc_in, input byte_t data);
        crc_t c;
        logic fb;
        c = crc_in;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[CRC_W-1] ^ data[i];
            c = {c[CRC_W-2:0], 1'b0};
            if (fb)
                c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    function automatic void clear_parse();
        cur_field = FIELD_GAP;
        bytes_left = '0;
        size_code = SIZE_RESET;
        running_crc = CRC_PRESET;
        low_pending = 1'b0;
        low_byte = '0;
    endfunction

    // tag one track byte and advance the parse state
    function automatic marked_byte_t mark_track_byte(input byte_t raw, input logic sot);
        marked_byte_t res;
        byte_t b;
        field_t fld;
        logic was_low;
        logic opened;
        b = raw;
        was_low = 1'b0;
        opened = 1'b0;
        if (sot)
            clear_parse();
        fld = cur_field;

        // a crc low byte owed from the previous byte replaces this one
        if (low_pending)
        begin
            b = low_byte;
            low_pending = 1'b0;
            was_low = 1'b1;
        end

        // mark substitution and crc insertion
        if (fix_enable)
        begin
            if (fld == FIELD_GAP)
            begin
                if (b == BYTE_F5)
                    b = BYTE_A1;
                else if (b == BYTE_F6)
                    b = BYTE_C2;
            end
            else if (fld == FIELD_CRC && !was_low && b == BYTE_CRC_MARK)
            begin
                b = running_crc[15:8];
                low_byte = running_crc[7:0];
                low_pending = 1'b1;
            end
        end

        res.out_byte = b;
        res.field_code = fld;

        // field counting, or mark detection in the gap
        if (bytes_left != 0)
        begin
            if (fld == FIELD_ID && bytes_left == 1)
                size_code = (b > SIZE_MAX) ? SIZE_MAX : size_t'(b);
            bytes_left = bytes_left - 1'b1;
            if (bytes_left == 0)
            begin
                if (fld < FIELD_CRC)
                begin
                    cur_field = FIELD_CRC;
                    bytes_left = CRC_LEN;
                end
                else
                    cur_field = FIELD_GAP;
            end
        end
        else
        begin
            opened = 1'b1;
            case (b)
                MARK_ID:
                begin
                    cur_field = FIELD_ID;
                    bytes_left = ID_LEN;
                end
                MARK_DATA:
                begin
                    cur_field = FIELD_DATA;
                    bytes_left = SECTOR_BASE << size_code;
                end
                MARK_DELETED:
                begin
                    cur_field = FIELD_DELETED;
                    bytes_left = SECTOR_BASE << size_code;
                end
                default:
                begin
                    cur_field = FIELD_GAP;
                    opened = 1'b0;
                end
            endcase
        end

        running_crc = crc_shift(opened ? CRC_PRESET : running_crc, b);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        marked_byte_t got;
        marked_byte_t want;
        if (!rst_n)
        begin
            fix_enable = 1'b1;
            clear_parse();
            expected_marks.delete();
            outstanding <= 0;
        end
        else
        begin
            // register write
            if (cfg_we)
                fix_enable = cfg_wdata;

            // track byte transfer
            if (track.valid && track.ready)
                expected_marks.insert(expected_marks.size(),
                                      mark_track_byte(track.track_byte,
                                                      track.start_of_track));

            // marked byte transfer
            if (marked.valid && marked.ready)
            begin
                got.out_byte = marked.out_byte;
                got.field_code = marked.field_code;
                if (expected_marks.size() == 0)
                    report_mismatch($sformatf("unexpected result byte %02h field %0d",
                                              got.out_byte, got.field_code));
                else
                begin
                    want = expected_marks.pop_front();
                    if (got.out_byte !== want.out_byte)
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  got.out_byte, want.out_byte));
                    if (got.field_code !== want.field_code)
                        report_mismatch($sformatf("field_code %0d, expected %0d",
                                                  got.field_code, want.field_code));
                end
            end
            outstanding <= expected_marks.size();
        end
    end

endmodule

### bench/floppy_track_field_marker_test.sv
`timescale 1ns / 1ps
module floppy_track_field_marker_test;
    import ftfm_pkg::*;

    localparam int QUIET_LIMIT = 2000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;
    logic steady = 1'b0;
    int   fail_count;
    int   outstanding;
    int   sent_count = 0;
    int   quiet_cycles = 0;

    ftfm_track_if track();
    ftfm_field_if marked();

    floppy_track_field_marker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .track     (track),
        .marked    (marked)
    );

    ftfm_field_check check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .track       (track),
        .marked      (marked),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog on cycles with no transfer at all
    always @(posedge clk)
    begin
        if ((track.valid && track.ready) || (marked.valid && marked.ready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("floppy_track_field_marker_test NOT OK");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off while bytes keep coming
    initial
    begin
        int taken = 0;
        int hold_left = 0;
        marked.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (marked.valid && marked.ready)
            begin
                taken++;
                if (taken == 100)
                    hold_left = 60;
            end
            if (hold_left > 0)
            begin
                marked.ready <= 1'b0;
                hold_left--;
            end
            else
                marked.ready <= steady || ($urandom_range(0, 99) >= 22);
        end
    end

    // one track byte transfer, with a random idle cycle ahead of it
    task automatic send_byte(input byte_t value, input logic sot);
        if (!steady && $urandom_range(0, 99) < 22)
        begin
            track.valid <= 1'b0;
            @(posedge clk);
        end
        track.valid <= 1'b1;
        track.track_byte <= value;
        track.start_of_track <= sot;
        @(posedge clk);
        while (!track.ready)
            @(posedge clk);
        sent_count++;
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    task automatic write_crc_fix(input logic value);
        track.valid <= 1'b0;
        wait_drained();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // gap filler, rich in the substitution bytes, never a mark
    function automatic byte_t gap_byte();
        byte_t b;
        case ($urandom_range(0, 7))
            0: b = BYTE_F5;
            1: b = BYTE_F6;
            2: b = BYTE_CRC_MARK;
            default:
            begin
                b = byte_t'($urandom);
                if (b == MARK_ID || b == MARK_DATA || b == MARK_DELETED)
                    b = 8'h4E;
            end
        endcase
        return b;
    endfunction

    function automatic byte_t body_byte();
        case ($urandom_range(0, 11))
            0: return BYTE_CRC_MARK;
            1: return BYTE_F5;
            2: return MARK_ID;
            default: return byte_t'($urandom);
        endcase
    endfunction

    task automatic send_crc();
        send_byte($urandom_range(0, 1) ? BYTE_CRC_MARK : byte_t'($urandom), 1'b0);
        send_byte(($urandom_range(0, 3) == 0) ? BYTE_CRC_MARK : byte_t'($urandom), 1'b0);
    endtask

    // one track: gaps, id fields and short sectors, some noise and cut-offs
    task automatic send_track();
        size_t sz;
        byte_t size_byte;
        int len;
        sz = SIZE_RESET;
        send_byte(gap_byte(), 1'b1);
        repeat ($urandom_range(1, 4))
        begin
            repeat ($urandom_range(0, 5))
                send_byte(gap_byte(), 1'b0);
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 8))
                    send_byte(byte_t'($urandom), 1'b0);
            end
            else if (sz <= 1 && $urandom_range(0, 2) == 0)
            begin
                send_byte($urandom_range(0, 1) ? MARK_DATA : MARK_DELETED, 1'b0);
                len = SECTOR_BASE << sz;
                // cut the track off inside the sector now and then
                if ($urandom_range(0, 7) == 0)
                begin
                    repeat ($urandom_range(1, len - 1))
                        send_byte(body_byte(), 1'b0);
                    return;
                end
                repeat (len)
                    send_byte(body_byte(), 1'b0);
                send_crc();
            end
            else
            begin
                send_byte(MARK_ID, 1'b0);
                repeat (3)
                    send_byte(byte_t'($urandom), 1'b0);
                case ($urandom_range(0, 9))
                    0: size_byte = byte_t'($urandom);
                    1, 2: size_byte = byte_t'($urandom_range(2, 7));
                    default: size_byte = byte_t'($urandom_range(0, 1));
                endcase
                send_byte(size_byte, 1'b0);
                sz = (size_byte > SIZE_MAX) ? SIZE_MAX : size_t'(size_byte);
                send_crc();
            end
        end
    endtask

    task automatic run_tracks(input int count);
        sent_count = 0;
        while (sent_count < count)
            send_track();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        track.valid = 1'b0;
        track.track_byte = '0;
        track.start_of_track = 1'b0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        write_crc_fix(1'b1);

        // substitution in the gap, f7 outside crc, mark inside a field
        send_byte(BYTE_F5, 1'b1);
        send_byte(BYTE_F6, 1'b0);
        send_byte(BYTE_CRC_MARK, 1'b0);
        send_byte(MARK_ID, 1'b0);
        send_byte(MARK_ID, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h00, 1'b0);
        // f7 as second crc byte: the low byte lands in the gap
        send_byte(8'h00, 1'b0);
        send_byte(BYTE_CRC_MARK, 1'b0);
        send_byte(8'h33, 1'b0);
        // size code clamped, then a pending low byte dropped by a new track
        send_byte(MARK_ID, 1'b1);
        repeat (4)
            send_byte(8'hFF, 1'b0);
        send_byte(BYTE_CRC_MARK, 1'b0);
        send_byte(MARK_DELETED, 1'b1);
        send_byte(MARK_DATA, 1'b1);
        send_byte(8'h00, 1'b1);

        run_tracks(60);

        // leave a crc low byte pending across the register write
        send_byte(8'h00, 1'b1);
        send_byte(MARK_ID, 1'b0);
        repeat (4)
            send_byte(8'h00, 1'b0);
        send_byte(BYTE_CRC_MARK, 1'b0);
        write_crc_fix(1'b0);
        send_byte(8'h4E, 1'b0);
        run_tracks(50);

        // fixing back on, first stretch without any idling
        write_crc_fix(1'b1);
        steady = 1'b1;
        run_tracks(60);
        steady = 1'b0;
        run_tracks(50);

        // oversized size code clamps to the largest sector, which runs past
        // the smallest sector length before the run ends inside it
        send_byte(gap_byte(), 1'b1);
        send_byte(MARK_ID, 1'b0);
        repeat (3)
            send_byte(byte_t'($urandom), 1'b0);
        send_byte(8'h08, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h4E, 1'b0);
        send_byte(MARK_DATA, 1'b0);
        repeat (150)
            send_byte(body_byte(), 1'b0);

        // drain and give the verdict
        track.valid <= 1'b0;
        wait_drained();
        repeat (4)
            @(posedge clk);
        if (fail_count == 0)
            $display("floppy_track_field_marker_test OK");
        else
            $display("floppy_track_field_marker_test NOT OK");
        $finish;
    end

endmodule
